[src/bmclp_pkg.sv]
// ----------------------------------------------------------------------------
// bmclp_pkg
// shared types and constants of the button click and long press detector
// ----------------------------------------------------------------------------
package bmclp_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned IdxW   = 2;

  localparam logic [CfgW-1:0] DebounceRst   = 16'd50;
  localparam logic [CfgW-1:0] ReleaseGapRst = 16'd500;
  localparam logic [CfgW-1:0] LongPressRst  = 16'd3000;

  localparam logic [CountW-1:0] CountMax = 8'hff;

  typedef enum logic [KindW-1:0] {
    EV_NONE  = 2'd0,
    EV_COUNT = 2'd1,
    EV_LONG  = 2'd2
  } event_kind_t;

  typedef enum logic [IdxW-1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_RELEASE_GAP = 2'd1,
    REG_LONG_PRESS  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [KindW-1:0]  event_kind;
    logic [CountW-1:0] press_count;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] release_gap_ms;
    logic [CfgW-1:0] long_press_ms;
  } cfg_t;

endpackage

[src/bmclp_core.sv]
// ----------------------------------------------------------------------------
// bmclp_core
// detector state and single-pass next-state and event logic for one sample
// ----------------------------------------------------------------------------
module bmclp_core
  import bmclp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              step_en,
  input  logic [TimeW-1:0]  now_ms,
  input  logic              pin_level,
  output result_t           result
);

  logic              saved_level_r,     saved_level_nxt;
  logic              press_latched_r,   press_latched_nxt;
  logic [CountW-1:0] pending_r,         pending_nxt;
  logic              long_reported_r,   long_reported_nxt;
  logic [TimeW-1:0]  last_press_r,      last_press_nxt;
  logic [TimeW-1:0]  lockout_until_r,   lockout_until_nxt;

  logic              pressed;
  logic              locked;
  logic              press_new;
  logic [CountW-1:0] pend_cnt;
  logic [TimeW-1:0]  elapsed;
  logic              gap_ev;
  logic              long_ev;

  always_comb begin
    pressed   = ~pin_level;
    locked    = now_ms < lockout_until_r;
    press_new = pressed & ~saved_level_r & ~press_latched_r;
    pend_cnt  = pending_r;
    if (press_new && pending_r != CountMax) begin
      pend_cnt = pending_r + 1'b1;
    end
    elapsed = press_new ? '0 : (now_ms - last_press_r);
    gap_ev  = (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.release_gap_ms}) & ~pressed &
              ((pend_cnt != '0) | long_reported_r);
    long_ev = (elapsed > {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms}) & pressed &
              ~long_reported_r & (pend_cnt == {{(CountW-1){1'b0}}, 1'b1});

    saved_level_nxt   = saved_level_r;
    press_latched_nxt = press_latched_r;
    pending_nxt       = pending_r;
    long_reported_nxt = long_reported_r;
    last_press_nxt    = last_press_r;
    lockout_until_nxt = lockout_until_r;
    result.event_kind  = EV_NONE;
    result.press_count = '0;

    if (!locked) begin
      press_latched_nxt = pressed & (press_latched_r | press_new);
      pending_nxt       = pend_cnt;
      if (press_new) begin
        lockout_until_nxt = now_ms + {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};
        last_press_nxt    = now_ms;
      end
      if (gap_ev) begin
        pending_nxt = '0;
        if (long_reported_r) begin
          long_reported_nxt = 1'b0;
        end else begin
          result.event_kind  = EV_COUNT;
          result.press_count = pend_cnt;
        end
      end else if (long_ev) begin
        pending_nxt       = '0;
        long_reported_nxt = 1'b1;
        result.event_kind = EV_LONG;
      end else begin
        saved_level_nxt = pressed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_level_r   <= 1'b0;
      press_latched_r <= 1'b0;
      pending_r       <= '0;
      long_reported_r <= 1'b0;
      last_press_r    <= '0;
      lockout_until_r <= '0;
    end else if (step_en) begin
      saved_level_r   <= saved_level_nxt;
      press_latched_r <= press_latched_nxt;
      pending_r       <= pending_nxt;
      long_reported_r <= long_reported_nxt;
      last_press_r    <= last_press_nxt;
      lockout_until_r <= lockout_until_nxt;
    end
  end

  a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.event_kind == EV_LONG |=> long_reported_r)
    else $error("long press event did not set long_reported");

  a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.event_kind == EV_COUNT |=> pending_r == '0)
    else $error("count event did not clear pending presses");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.event_kind == EV_COUNT |-> result.press_count != '0)
    else $error("count event with zero presses");

  a_lock_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && locked |=> $stable(pending_r) && $stable(lockout_until_r))
    else $error("state changed during lockout");

endmodule

[src/bmclp_out_reg.sv]
// ----------------------------------------------------------------------------
// bmclp_out_reg
// result register holding one beat until the downstream side takes it
// ----------------------------------------------------------------------------
module bmclp_out_reg
  import bmclp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  result_t           res,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KindW-1:0]  out_event_kind,
  output logic [CountW-1:0] out_press_count
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign res_ready = ~valid_r | out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid && res_ready) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_event_kind  = res_r.event_kind;
  assign out_press_count = res_r.press_count;

endmodule

[src/button_multi_click_long_press_top.sv]
// ----------------------------------------------------------------------------
// button_multi_click_long_press_top
// One sample beat in, one result beat out. A sample is taken into an input
// register, evaluated combinationally against the detector state and written
// to the result register once that register can take it, so a result passes
// through the input register and then the result register. A new sample is
// taken every cycle while the result side keeps up. Throughput is one beat
// per cycle while the result side keeps up, set by the state update loop in
// the core. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module button_multi_click_long_press_top
  import bmclp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TimeW-1:0]  in_now_ms,
  input  logic              in_pin_level,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KindW-1:0]  out_event_kind,
  output logic [CountW-1:0] out_press_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]   cfg_data
);

  cfg_t             cfg_r;
  logic             in_valid_r, in_valid_nxt;
  logic [TimeW-1:0] now_r;
  logic             pin_r;
  logic             res_ready;
  logic             step_en;
  result_t          result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms    <= DebounceRst;
      cfg_r.release_gap_ms <= ReleaseGapRst;
      cfg_r.long_press_ms  <= LongPressRst;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg_r.debounce_ms    <= cfg_data;
        REG_RELEASE_GAP: cfg_r.release_gap_ms <= cfg_data;
        REG_LONG_PRESS:  cfg_r.long_press_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step_en  = in_valid_r & res_ready;
  assign in_ready = ~in_valid_r | step_en;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      now_r <= in_now_ms;
      pin_r <= in_pin_level;
    end
  end

  bmclp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step_en   (step_en),
    .now_ms    (now_r),
    .pin_level (pin_r),
    .result    (result)
  );

  bmclp_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (in_valid_r),
    .res_ready       (res_ready),
    .res             (result),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_press_count (out_press_count)
  );

endmodule

[tb/sv/bmclp_event_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmclp_event_checker
// Watches the sample, result and register write channels of the button
// click and long press detector. Every accepted sample is run through a
// local model of the detector, and the event it should produce is queued.
// Every accepted result beat is compared field by field with the oldest
// queued event. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module bmclp_event_checker
  import bmclp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [TimeW-1:0]  in_now_ms,
  input  logic              in_pin_level,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KindW-1:0]  out_event_kind,
  input  logic [CountW-1:0] out_press_count,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [CfgW-1:0]   cfg_data,
  output int                fail_count,
  output int                outstanding
);

  logic [CfgW-1:0]   debounce_ms;
  logic [CfgW-1:0]   release_gap_ms;
  logic [CfgW-1:0]   long_press_ms;

  logic              saved_pressed;
  logic              press_latched;
  logic              long_reported;
  logic [CountW-1:0] pending_presses;
  logic [TimeW-1:0]  last_press_ms;
  logic [TimeW-1:0]  lockout_end;

  result_t           expected_events[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic result_t detect_event(input logic [TimeW-1:0] now_ms,
                                           input logic pin_level);
    result_t          res;
    logic             pressed;
    logic [TimeW-1:0] since_press;
    res.event_kind  = EV_NONE;
    res.press_count = '0;
    pressed = ~pin_level;
    // samples inside the debounce window leave everything untouched
    if (now_ms < lockout_end) return res;
    if (pressed && !saved_pressed && !press_latched) begin
      if (pending_presses != CountMax) pending_presses++;
      press_latched = 1'b1;
      lockout_end   = now_ms + TimeW'(debounce_ms);
      last_press_ms = now_ms;
    end
    if (!pressed) press_latched = 1'b0;
    since_press = now_ms - last_press_ms;
    if (since_press > TimeW'(release_gap_ms) && !pressed &&
        (pending_presses != 0 || long_reported)) begin
      // release after a long press closes it silently
      if (!long_reported) begin
        res.event_kind  = EV_COUNT;
        res.press_count = pending_presses;
      end
      long_reported   = 1'b0;
      pending_presses = '0;
      return res;
    end
    if (since_press > TimeW'(long_press_ms) && pressed && !long_reported &&
        pending_presses == 1) begin
      pending_presses = '0;
      long_reported   = 1'b1;
      res.event_kind  = EV_LONG;
      return res;
    end
    saved_pressed = pressed;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      debounce_ms     = DebounceRst;
      release_gap_ms  = ReleaseGapRst;
      long_press_ms   = LongPressRst;
      saved_pressed   = 1'b0;
      press_latched   = 1'b0;
      long_reported   = 1'b0;
      pending_presses = '0;
      last_press_ms   = '0;
      lockout_end     = '0;
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result beat kind %0d count %0d with none expected",
                                    out_event_kind, out_press_count));
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.event_kind)
            report_mismatch($sformatf("event_kind got %0d expected %0d",
                                      out_event_kind, want.event_kind));
          if (out_press_count !== want.press_count)
            report_mismatch($sformatf("press_count got %0d expected %0d",
                                      out_press_count, want.press_count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:    debounce_ms    = cfg_data;
          REG_RELEASE_GAP: release_gap_ms = cfg_data;
          REG_LONG_PRESS:  long_press_ms  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_events.push_back(detect_event(in_now_ms, in_pin_level));
    end
    outstanding = expected_events.size();
  end

endmodule

[tb/sv/button_multi_click_long_press_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_multi_click_long_press_top_tb
// Drives timestamped button samples into the detector: a directed part for
// debounce lockout, gap and hold boundaries, timestamp wrap, long press and
// zero and full scale settings, then random click bursts, long presses,
// bounce, noise and time jumps under several register settings. Both sides
// stall at random, and the result side holds off once for a long stretch.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module button_multi_click_long_press_top_tb;
  import bmclp_pkg::*;

  localparam int unsigned     ItemTarget    = 1800;
  localparam int unsigned     PhaseItems    = 250;
  localparam int unsigned     HoldOffCycles = 300;
  localparam int unsigned     LimitCycles   = 200000;
  localparam logic [IdxW-1:0] RegSpare      = 2'd3;
  localparam logic            PinReleased   = 1'b1;
  localparam logic            PinPressed    = 1'b0;
  localparam logic [TimeW-1:0] TimeTop      = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [TimeW-1:0]  in_now_ms;
  logic              in_pin_level;
  logic              out_valid;
  logic              out_ready;
  logic [KindW-1:0]  out_event_kind;
  logic [CountW-1:0] out_press_count;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index;
  logic [CfgW-1:0]   cfg_data;

  int                fail_count;
  int                outstanding;

  logic              squeeze_req = 1'b0;
  logic              hold_off;
  bit                steady = 1'b0;
  logic [TimeW-1:0]  clock_ms;
  int unsigned       sent_count;
  int unsigned       deb_ms;
  int unsigned       gap_ms;
  int unsigned       hold_ms;

  button_multi_click_long_press_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_now_ms       (in_now_ms),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_press_count (out_press_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  bmclp_event_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_now_ms       (in_now_ms),
    .in_pin_level    (in_pin_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_press_count (out_press_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * LimitCycles);
    $display("button_multi_click_long_press_top_tb failed");
    $finish;
  end

  // result side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ready = 1'b0;
      else          out_ready = steady || ($urandom_range(99) >= 11);
    end
  end

  // long hold-off on the result side so the block backs up
  initial begin
    hold_off = 1'b0;
    wait (squeeze_req);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_sample(input logic [TimeW-1:0] stamp, input logic pin);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_now_ms    = stamp;
    in_pin_level = pin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_DEBOUNCE:    deb_ms  = 32'(value);
      REG_RELEASE_GAP: gap_ms  = 32'(value);
      REG_LONG_PRESS:  hold_ms = 32'(value);
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned deb, input int unsigned gap,
                            input int unsigned hold);
    write_reg(REG_DEBOUNCE, CfgW'(deb));
    write_reg(REG_RELEASE_GAP, CfgW'(gap));
    write_reg(REG_LONG_PRESS, CfgW'(hold));
    write_reg(RegSpare, CfgW'($urandom));
  endtask

  // wrap only from the top of the range, after a press there, so the
  // lockout deadline wraps with the clock
  task automatic wrap_clock();
    send_sample(TimeTop, PinReleased);
    send_sample(TimeTop, PinReleased);
    send_sample(TimeTop, PinPressed);
    clock_ms = TimeTop;
  endtask

  task automatic advance(input int unsigned delta);
    logic [TimeW-1:0] next_ms;
    next_ms = clock_ms + delta;
    if (next_ms < clock_ms) begin
      wrap_clock();
      next_ms = clock_ms + delta;
    end
    clock_ms = next_ms;
  endtask

  task automatic hold_level(input logic pin, input int unsigned dur,
                            input int unsigned max_samples);
    int unsigned samples;
    int unsigned left;
    int unsigned step;
    samples = $urandom_range(1, max_samples);
    left    = dur;
    for (int i = 1; i <= samples; i++) begin
      step = (i == samples) ? left : $urandom_range(0, left);
      left -= step;
      advance(step);
      send_sample(clock_ms, pin);
    end
  endtask

  task automatic click_burst(input int unsigned clicks, input int unsigned press_max,
                             input int unsigned spacing_max,
                             input int unsigned max_samples);
    repeat (clicks) begin
      hold_level(PinPressed, $urandom_range(0, press_max), max_samples);
      hold_level(PinReleased, deb_ms + $urandom_range(0, spacing_max), max_samples);
    end
    hold_level(PinReleased, gap_ms + $urandom_range(1, gap_ms + 2), max_samples);
  endtask

  task automatic run_gesture();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      click_burst($urandom_range(1, 4), hold_ms + deb_ms, gap_ms, 3);
    end else if (pick < 63) begin
      hold_level(PinPressed, deb_ms + hold_ms + $urandom_range(0, hold_ms / 2 + 2), 4);
      hold_level(PinReleased, gap_ms + $urandom_range(1, gap_ms + 2), 3);
    end else if (pick < 78) begin
      // contact bounce
      repeat ($urandom_range(2, 8))
        hold_level(1'($urandom_range(0, 1)), $urandom_range(0, deb_ms + 2), 2);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 4)) begin
        if (clock_ms > 32'd100000 && $urandom_range(0, 1) == 1)
          clock_ms -= $urandom_range(0, 64);
        else
          advance($urandom_range(0, 2 * gap_ms + 8));
        send_sample(clock_ms, 1'($urandom_range(0, 1)));
      end
    end else begin
      advance($urandom_range(0, 32'h4000_0000));
      send_sample(clock_ms, PinReleased);
    end
  endtask

  initial begin
    int unsigned random_end;
    int unsigned phase_start;
    int unsigned phase_end;
    int unsigned phase;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_now_ms    = '0;
    in_pin_level = PinReleased;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DEBOUNCE;
    cfg_data     = '0;
    sent_count   = 0;
    deb_ms       = 32'(DebounceRst);
    gap_ms       = 32'(ReleaseGapRst);
    hold_ms      = 32'(LongPressRst);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: lockout, exact release gap
    send_sample(32'd1000, PinReleased);
    send_sample(32'd1000, PinPressed);
    send_sample(32'd1020, PinReleased);
    send_sample(32'd1050, PinReleased);
    send_sample(32'd1500, PinReleased);
    send_sample(32'd1501, PinReleased);
    // lockout across the wrap, then a deadline that wraps
    send_sample(32'hFFFF_FF00, PinPressed);
    send_sample(32'h0000_0005, PinReleased);
    send_sample(32'hFFFF_FF40, PinReleased);
    send_sample(32'hFFFF_FFF0, PinPressed);
    send_sample(32'h0000_0030, PinReleased);
    send_sample(32'h0000_0300, PinReleased);
    // long press, then a press counted before its release
    send_sample(32'h0000_1000, PinPressed);
    send_sample(32'h0000_2000, PinPressed);
    send_sample(32'h0000_1040, PinReleased);
    send_sample(32'h0000_1050, PinPressed);
    send_sample(32'h0000_1300, PinReleased);
    drain_results();

    // zero thresholds still need one ms
    set_config(0, 0, 0);
    clock_ms = 32'h0010_0000;
    send_sample(clock_ms, PinReleased);
    send_sample(clock_ms, PinPressed);
    send_sample(clock_ms + 1, PinPressed);
    send_sample(clock_ms + 1, PinReleased);
    send_sample(clock_ms + 2, PinReleased);
    send_sample(clock_ms + 2, PinPressed);
    send_sample(clock_ms + 3, PinReleased);
    drain_results();

    // full scale thresholds
    set_config(65535, 65535, 65535);
    clock_ms = 32'h0200_0000;
    send_sample(clock_ms, PinReleased);
    send_sample(clock_ms + 1, PinPressed);
    send_sample(clock_ms + 65536, PinReleased);
    send_sample(clock_ms + 65537, PinReleased);
    send_sample(clock_ms + 200000, PinPressed);
    send_sample(clock_ms + 265535, PinPressed);
    send_sample(clock_ms + 265536, PinPressed);
    send_sample(clock_ms + 265537, PinReleased);
    clock_ms = clock_ms + 265537;

    random_end = sent_count + ItemTarget;
    phase = 0;
    while (sent_count < random_end) begin
      drain_results();
      case (phase)
        1:       set_config($urandom_range(1, 4), $urandom_range(100, 200), 1000);
        2:       set_config($urandom_range(1, 300), $urandom_range(0, 3000),
                            $urandom_range(0, 8000));
        default: set_config($urandom_range(1, 12), $urandom_range(0, 40),
                            $urandom_range(0, 90));
      endcase
      steady      = (phase == 0);
      phase_start = sent_count;
      phase_end   = sent_count + PhaseItems;
      // enough clicks to saturate the count
      if (phase == 1) click_burst(260, 2, 3, 1);
      while (sent_count < phase_end) begin
        if (phase == 3 && sent_count >= phase_start + 40) squeeze_req = 1'b1;
        run_gesture();
      end
      phase++;
    end
    steady = 1'b0;
    drain_results();

    if (fail_count == 0) begin
      $display("button_multi_click_long_press_top_tb passed");
    end else begin
      $display("button_multi_click_long_press_top_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bmclp_pkg.sv
src/bmclp_core.sv
src/bmclp_out_reg.sv
src/button_multi_click_long_press_top.sv
tb/sv/bmclp_event_checker.sv
tb/sv/button_multi_click_long_press_top_tb.sv
